/* sv/newline_message_ring_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the newline message ring queue
// Shared property forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef NEWLINE_MESSAGE_RING_QUEUE_UNIT_DEFINES_SVH
`define NEWLINE_MESSAGE_RING_QUEUE_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define NMRQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("%m: invariant violated");

// antecedent implies consequent in the same cycle
`define NMRQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

`endif

/* sv/nmrq_pkg.sv */
// ----------------------------------------------------------------------------
// nmrq_pkg
// Types, codes and constants shared by the message ring queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nmrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam logic [7:0] NEWLINE = 8'd10;
    localparam logic [6:0] LEN_CAP = 7'd127;

    typedef enum logic [2:0] {
        KIND_WR_COMMIT   = 3'd0,
        KIND_WR_REJECT   = 3'd1,
        KIND_RD_BYTE     = 3'd2,
        KIND_RD_EMPTY    = 3'd3,
        KIND_RD_TOO_LONG = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_NEWLINE = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] data;
        logic [7:0] cap;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/newline_message_ring_queue_unit.sv */
// ----------------------------------------------------------------------------
// newline_message_ring_queue_unit
// Byte ring queue of newline-terminated messages with a stream interface.
// ----------------------------------------------------------------------------
// channel   dir  tdata                              tuser       tlast
// s_axis    in   [7:0] data_byte [15:8] capacity    [0] opcode  -
// m_axis    out  [7:0] out_byte [14:8] msg_length   [2:0] kind  last
//
// Write byte: needs no m_axis slot; a newline also loads one status item.
// Read of a message: the ring is scanned through its registered read port to
// the newline, then it streams out, one byte a cycle while m_axis is ready.
// Reset: control state only; the byte ring is not cleared and needs no pass.
// A stall on m_axis holds the back at a newline, a read or a streamed byte;
// earlier bytes are still stored; the front and two-entry command queue fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module newline_message_ring_queue_unit #(
    parameter int QUEUE_DEPTH = nmrq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [15:0]   i_s_axis_tdata,   // data_byte, capacity
    input  wire logic          i_s_axis_tuser,   // opcode
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata,   // out_byte, msg_length, zero
    output logic [2:0]         o_m_axis_tuser,   // kind
    output logic               o_m_axis_tlast
);

    logic           front_vld;
    nmrq_pkg::t_cmd front_cmd;
    logic           q_rdy;
    logic           q_vld;
    nmrq_pkg::t_cmd q_cmd;
    logic           q_pop;

    nmrq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .o_cmd_vld (front_vld),
        .o_cmd     (front_cmd),
        .i_cmd_rdy (q_rdy)
    );

    nmrq_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_cmd   (front_cmd),
        .o_rdy   (q_rdy),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    nmrq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_cmd),
        .o_cmd_pop (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/nmrq_front.sv */
// ----------------------------------------------------------------------------
// nmrq_front
// Accepts input items, classifies them into byte, newline or read commands
// and holds one command in a register until the queue takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmrq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tvalid,
    output logic               o_tready,
    input  wire logic [15:0]   i_tdata,
    input  wire logic          i_tuser,
    output logic               o_cmd_vld,
    output nmrq_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_rdy
);

    logic           r_vld;
    nmrq_pkg::t_cmd r_cmd;
    nmrq_pkg::t_cmd n_cmd;

    assign o_tready  = !r_vld || i_cmd_rdy;
    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

    always_comb begin
        n_cmd.data = i_tdata[7:0];
        n_cmd.cap  = i_tdata[15:8];
        if (i_tuser) begin
            n_cmd.op = nmrq_pkg::CMD_READ;
        end else if (i_tdata[7:0] == nmrq_pkg::NEWLINE) begin
            n_cmd.op = nmrq_pkg::CMD_NEWLINE;
        end else begin
            n_cmd.op = nmrq_pkg::CMD_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_tready) begin
            r_vld <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/nmrq_cmd_queue.sv */
// ----------------------------------------------------------------------------
// nmrq_cmd_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nmrq_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire nmrq_pkg::t_cmd i_cmd,
    output logic               o_rdy,
    output logic               o_vld,
    output nmrq_pkg::t_cmd     o_cmd,
    input  wire logic          i_pop
);

    nmrq_pkg::t_cmd r_ent [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_rdy   = (r_count != 2'd2);
    assign o_vld   = (r_count != 2'd0);
    assign o_cmd   = r_ent[r_rd_ptr];
    assign do_push = i_push && o_rdy;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/nmrq_back.sv */
// ----------------------------------------------------------------------------
// nmrq_back
// Executes commands against the byte ring: stores message bytes, commits or
// rejects at the newline, scans for the oldest message and streams it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "newline_message_ring_queue_unit_defines.svh"

module nmrq_back #(
    parameter int QUEUE_DEPTH = nmrq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_vld,
    input  wire nmrq_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [15:0]        o_tdata,
    output logic [2:0]         o_tuser,
    output logic               o_tlast
);

    localparam int AW       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_MAX = (QUEUE_DEPTH > 127) ? QUEUE_DEPTH : 127;
    localparam int PEND_W   = $clog2(PEND_MAX + 1);
    localparam int W        = ((PEND_W > CNT_W) ? PEND_W : CNT_W) + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [AW-1:0]       r_wptr, n_wptr;
    logic [AW-1:0]       r_saddr, n_saddr;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [PEND_W-1:0]   r_pend, n_pend;
    logic                r_drop, n_drop;
    logic [CNT_W-1:0]    r_k, n_k;
    logic [CNT_W-1:0]    r_len, n_len;
    logic [7:0]          r_cap, n_cap;
    logic                r_ovld, n_ovld;
    nmrq_pkg::t_kind     r_okind, n_okind;
    logic [7:0]          r_obyte, n_obyte;
    logic [6:0]          r_olen, n_olen;
    logic                r_olast, n_olast;

    logic [7:0]          r_mem [QUEUE_DEPTH];
    logic [7:0]          r_rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [6:0] f_sat(input logic [W-1:0] x);
        return (x > W'(nmrq_pkg::LEN_CAP)) ? nmrq_pkg::LEN_CAP : x[6:0];
    endfunction

    always_comb begin
        logic             slot_free;
        logic [CNT_W-1:0] used;
        logic [W-1:0]     nl_len;
        logic [CNT_W-1:0] found_len;

        slot_free = !r_ovld || i_tready;
        used      = CNT_W'(QUEUE_DEPTH) - r_free;
        nl_len    = W'(r_pend) + W'(1);
        found_len = r_k + 1'b1;

        n_state = r_state;
        n_head  = r_head;
        n_tail  = r_tail;
        n_wptr  = r_wptr;
        n_saddr = r_saddr;
        n_free  = r_free;
        n_pend  = r_pend;
        n_drop  = r_drop;
        n_k     = r_k;
        n_len   = r_len;
        n_cap   = r_cap;
        n_ovld  = r_ovld && !i_tready;
        n_okind = r_okind;
        n_obyte = r_obyte;
        n_olen  = r_olen;
        n_olast = r_olast;
        o_cmd_pop = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_wptr;
        wr_data = i_cmd.data;
        rd_en   = 1'b0;
        rd_addr = r_head;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld && (i_cmd.op == nmrq_pkg::CMD_BYTE || slot_free)) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        nmrq_pkg::CMD_BYTE: begin
                            if (!r_drop && (W'(r_pend) + W'(2) < W'(r_free))) begin
                                wr_en = 1'b1;
                            end else begin
                                n_drop = 1'b1;
                            end
                            if (r_pend != PEND_W'(PEND_MAX)) begin
                                n_pend = r_pend + 1'b1;
                            end
                            n_wptr = f_inc(r_wptr);
                        end
                        nmrq_pkg::CMD_NEWLINE: begin
                            n_ovld  = 1'b1;
                            n_obyte = 8'd0;
                            n_olen  = f_sat(nl_len);
                            n_olast = 1'b1;
                            if (!r_drop && (nl_len < W'(r_free))) begin
                                wr_en   = 1'b1;
                                n_tail  = f_inc(r_wptr);
                                n_wptr  = f_inc(r_wptr);
                                n_free  = r_free - CNT_W'(nl_len);
                                n_okind = nmrq_pkg::KIND_WR_COMMIT;
                            end else begin
                                n_wptr  = r_tail;
                                n_okind = nmrq_pkg::KIND_WR_REJECT;
                            end
                            n_pend = '0;
                            n_drop = 1'b0;
                        end
                        nmrq_pkg::CMD_READ: begin
                            n_cap = i_cmd.cap;
                            if (r_free == CNT_W'(QUEUE_DEPTH)) begin
                                n_ovld  = 1'b1;
                                n_okind = nmrq_pkg::KIND_RD_EMPTY;
                                n_obyte = 8'd0;
                                n_olen  = 7'd0;
                                n_olast = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_saddr = r_head;
                                n_k     = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_rd_data == nmrq_pkg::NEWLINE) begin
                    if (W'(found_len) > W'(r_cap)) begin
                        n_ovld  = 1'b1;
                        n_okind = nmrq_pkg::KIND_RD_TOO_LONG;
                        n_obyte = 8'd0;
                        n_olen  = f_sat(W'(found_len));
                        n_olast = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_len   = found_len;
                        n_k     = '0;
                        rd_en   = 1'b1;
                        rd_addr = r_head;
                        n_state = ST_EMIT;
                    end
                end else if (found_len == used) begin
                    n_ovld  = 1'b1;
                    n_okind = nmrq_pkg::KIND_RD_EMPTY;
                    n_obyte = 8'd0;
                    n_olen  = 7'd0;
                    n_olast = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_k     = found_len;
                    rd_en   = 1'b1;
                    rd_addr = f_inc(r_saddr);
                    n_saddr = f_inc(r_saddr);
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovld  = 1'b1;
                    n_okind = nmrq_pkg::KIND_RD_BYTE;
                    n_obyte = r_rd_data;
                    n_olen  = f_sat(W'(r_len));
                    n_olast = (r_k == r_len - 1'b1);
                    n_head  = f_inc(r_head);
                    n_free  = r_free + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = f_inc(r_head);
                    if (r_k == r_len - 1'b1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_wptr  <= '0;
            r_free  <= CNT_W'(QUEUE_DEPTH);
            r_pend  <= '0;
            r_drop  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_wptr  <= n_wptr;
            r_free  <= n_free;
            r_pend  <= n_pend;
            r_drop  <= n_drop;
            r_ovld  <= n_ovld;
        end
        r_saddr <= n_saddr;
        r_k     <= n_k;
        r_len   <= n_len;
        r_cap   <= n_cap;
        r_okind <= n_okind;
        r_obyte <= n_obyte;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_tvalid = r_ovld;
    assign o_tdata  = {1'b0, r_olen, r_obyte};
    assign o_tuser  = r_okind;
    assign o_tlast  = r_olast;

    `NMRQ_ASSERT_ALWAYS(a_free_range, i_clk, i_rst_n, r_free <= CNT_W'(QUEUE_DEPTH))
    `NMRQ_ASSERT_IMPLIES(a_scan_slot_empty, i_clk, i_rst_n, r_state == ST_SCAN, !r_ovld)
    `NMRQ_ASSERT_IMPLIES(a_wptr_at_tail, i_clk, i_rst_n, r_pend == '0, r_wptr == r_tail)
    `NMRQ_ASSERT_IMPLIES(a_drop_pending, i_clk, i_rst_n, r_drop, r_pend != '0)

endmodule

`default_nettype wire
